@@ src/evsn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package evsn_pkg;

  // Table geometry
  localparam int GLOBAL_EVENTS = 16;
  localparam int TASK_EVENTS   = 8;
  localparam int NUM_TASKS     = 4;
  localparam int SLOT_COUNT    = GLOBAL_EVENTS + NUM_TASKS * TASK_EVENTS;
  localparam int SLOT_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Fixed field widths
  localparam int REQ_W    = 3;
  localparam int EVT_W    = 8;
  localparam int TASK_W   = 2;
  localparam int WORD_W   = 64;
  localparam int SERIAL_W = 32;
  localparam int STAT_W   = 3;
  localparam int HOOK_W   = 16;
  localparam int HOOK_IDX_W = $clog2(HOOK_W);

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_NOTIFY    = 3'd0,
    REQ_SUBSCRIBE = 3'd1,
    REQ_UNSUB     = 3'd2,
    REQ_UNMASK    = 3'd3,
    REQ_CLEANUP   = 3'd4
  } req_e_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_NOMEM = 3'd1,
    ST_BUSY  = 3'd2,
    ST_NOSUB = 3'd3,
    ST_EXIST = 3'd4,
    ST_LIMIT = 3'd5
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_CLEAN = 2'd2
  } state_t;

  // One slot entry as held in the table memory (subscribed lives in flops)
  typedef struct packed {
    logic [TASK_W-1:0]   owner;
    logic [WORD_W-1:0]   method;
    logic [SERIAL_W-1:0] serial;
    logic                masked;
  } slot_t;

  // Controller to datapath
  typedef struct packed {
    logic take;    // latch request, launch first table read
    logic clean;   // one cleanup step on the slot in the read register
    logic commit;  // update the slot and load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_clean;   // request on the input is a cleanup
    logic clean_last;  // current cleanup step is the last global slot
    logic out_free;    // result register can take a new transaction
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ src/event_subscription_notifier_core.sv @@
// Channel | Handshake           | Payload
// --------+---------------------+-----------------------------------------------
// in_     | in_valid, in_stall  | req_type, event_number, task_slot, method,
//         |                     | mask_after, alloc_ok, sender_id, arg_one..five
// out_    | out_valid,out_stall | status, notif_*, out_arg_one..five, unmask_hook
// cfg_    | cfg_wr_en           | cfg_wr_data (unmask hook enable, 16 bits)
//
// Notify, subscribe, unsubscribe and unmask do a table read, then decide and
// write back into the slot memory (separate read and write ports).
// Cleanup walks the global slots, one global slot per cycle, then commits.
// One transaction is in work at a time; the next is taken while a result waits.
// Reset (rst_n low, synchronous) clears subscribed flags, hook enables and
// control; the slot memory itself is not cleared, a free slot's content is unused.
// A stalled result holds; a result waiting at the output holds the block in
// its final cycle until taken.
`timescale 1ns / 1ps
`default_nettype none

module event_subscription_notifier_core
  import evsn_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [HOOK_W-1:0]   cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [REQ_W-1:0]    in_req_type,
  input  wire logic [EVT_W-1:0]    in_event_number,
  input  wire logic [TASK_W-1:0]   in_task_slot,
  input  wire logic [WORD_W-1:0]   in_method,
  input  wire logic                in_mask_after,
  input  wire logic                in_alloc_ok,
  input  wire logic [WORD_W-1:0]   in_sender_id,
  input  wire logic [WORD_W-1:0]   in_arg_one,
  input  wire logic [WORD_W-1:0]   in_arg_two,
  input  wire logic [WORD_W-1:0]   in_arg_three,
  input  wire logic [WORD_W-1:0]   in_arg_four,
  input  wire logic [WORD_W-1:0]   in_arg_five,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_notif_valid,
  output logic [TASK_W-1:0]        out_notif_owner,
  output logic [WORD_W-1:0]        out_notif_method,
  output logic [SERIAL_W-1:0]      out_notif_serial,
  output logic [WORD_W-1:0]        out_notif_sender,
  output logic [WORD_W-1:0]        out_arg_one,
  output logic [WORD_W-1:0]        out_arg_two,
  output logic [WORD_W-1:0]        out_arg_three,
  output logic [WORD_W-1:0]        out_arg_four,
  output logic [WORD_W-1:0]        out_arg_five,
  output logic                     out_unmask_hook
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer
  evsn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slot table, decision logic and result register
  evsn_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_req_type      (in_req_type),
    .in_event_number  (in_event_number),
    .in_task_slot     (in_task_slot),
    .in_method        (in_method),
    .in_mask_after    (in_mask_after),
    .in_alloc_ok      (in_alloc_ok),
    .in_sender_id     (in_sender_id),
    .in_arg_one       (in_arg_one),
    .in_arg_two       (in_arg_two),
    .in_arg_three     (in_arg_three),
    .in_arg_four      (in_arg_four),
    .in_arg_five      (in_arg_five),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_notif_valid  (out_notif_valid),
    .out_notif_owner  (out_notif_owner),
    .out_notif_method (out_notif_method),
    .out_notif_serial (out_notif_serial),
    .out_notif_sender (out_notif_sender),
    .out_arg_one      (out_arg_one),
    .out_arg_two      (out_arg_two),
    .out_arg_three    (out_arg_three),
    .out_arg_four     (out_arg_four),
    .out_arg_five     (out_arg_five),
    .out_unmask_hook  (out_unmask_hook),
    .cmd              (cmd),
    .sts              (sts)
  );

`ifndef SYNTHESIS
  // One transaction at a time: the block is busy the cycle after a take
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous transaction still in work");

  // A notification only goes with an ok status
  a_notif_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_notif_valid |-> out_status == ST_OK)
    else $error("notification with failing status");

  // Hook and notification never come together
  a_hook_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unmask_hook |-> !out_notif_valid && out_status == ST_OK)
    else $error("unmask hook on a non-unmask result");

  // No result appears without a transaction having been taken before
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised while block was idle");
`endif

endmodule

`default_nettype wire

@@ src/evsn_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module evsn_ctrl
  import evsn_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = sts.req_clean ? S_CLEAN : S_EXEC;
        end
      end
      S_CLEAN: begin
        cmd.clean = 1'b1;
        if (sts.clean_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/evsn_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module evsn_dp
  import evsn_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                cfg_wr_en,
  input  wire logic [HOOK_W-1:0]   cfg_wr_data,
  // request fields
  input  wire logic [REQ_W-1:0]    in_req_type,
  input  wire logic [EVT_W-1:0]    in_event_number,
  input  wire logic [TASK_W-1:0]   in_task_slot,
  input  wire logic [WORD_W-1:0]   in_method,
  input  wire logic                in_mask_after,
  input  wire logic                in_alloc_ok,
  input  wire logic [WORD_W-1:0]   in_sender_id,
  input  wire logic [WORD_W-1:0]   in_arg_one,
  input  wire logic [WORD_W-1:0]   in_arg_two,
  input  wire logic [WORD_W-1:0]   in_arg_three,
  input  wire logic [WORD_W-1:0]   in_arg_four,
  input  wire logic [WORD_W-1:0]   in_arg_five,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_notif_valid,
  output logic [TASK_W-1:0]        out_notif_owner,
  output logic [WORD_W-1:0]        out_notif_method,
  output logic [SERIAL_W-1:0]      out_notif_serial,
  output logic [WORD_W-1:0]        out_notif_sender,
  output logic [WORD_W-1:0]        out_arg_one,
  output logic [WORD_W-1:0]        out_arg_two,
  output logic [WORD_W-1:0]        out_arg_three,
  output logic [WORD_W-1:0]        out_arg_four,
  output logic [WORD_W-1:0]        out_arg_five,
  output logic                     out_unmask_hook,
  // controller link
  input  wire ctrl_cmd_t           cmd,
  output ctrl_sts_t                sts
);

  // Slot table and subscribed flags
  slot_t             mem [SLOT_COUNT];
  slot_t             rd_data_r;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  slot_t             wr_data;
  logic [SLOT_COUNT-1:0] sub_r;

  logic [HOOK_W-1:0] hook_en_r;

  // Latched request
  logic [REQ_W-1:0]    req_r;
  logic [TASK_W-1:0]   task_r;
  logic [SLOT_W-1:0]   idx_r;
  logic                limit_r;
  logic [WORD_W-1:0]   method_r;
  logic                mask_after_r;
  logic                alloc_ok_r;
  logic [WORD_W-1:0]   sender_r;
  logic [WORD_W-1:0]   arg1_r, arg2_r, arg3_r, arg4_r, arg5_r;
  logic [SLOT_W-1:0]   cnt_r;

  // Decoded input request
  logic              in_global;
  logic              in_limit;
  logic [SLOT_W-1:0] in_idx;

  // Commit decision
  status_t             st;
  logic                nv;
  logic                hook;
  logic                set_sub, clr_sub;
  logic                cur_sub;
  logic [SERIAL_W-1:0] new_serial;
  logic                clean_hit;

  // Result register
  logic                out_valid_r;
  logic [STAT_W-1:0]   status_r;
  logic                nv_r;
  logic [TASK_W-1:0]   owner_r;
  logic [WORD_W-1:0]   nmethod_r;
  logic [SERIAL_W-1:0] serial_r;
  logic [WORD_W-1:0]   nsender_r;
  logic [WORD_W-1:0]   oarg1_r, oarg2_r, oarg3_r, oarg4_r, oarg5_r;
  logic                hook_r;

  // Event number to slot index, range checks
  always_comb begin
    in_global = int'(in_event_number) < GLOBAL_EVENTS;
    in_limit  = (in_req_type > REQ_CLEANUP) ||
                (!in_global &&
                 ((int'(in_event_number) >= GLOBAL_EVENTS + TASK_EVENTS) ||
                  (int'(in_task_slot) >= NUM_TASKS)));
    if (in_global) begin
      in_idx = SLOT_W'(in_event_number);
    end else begin
      in_idx = SLOT_W'(int'(in_task_slot) * TASK_EVENTS + int'(in_event_number));
    end
  end

  // Table read port: request slot on take, next global slot during cleanup
  always_comb begin
    rd_en   = cmd.take | cmd.clean;
    rd_addr = SLOT_W'(cnt_r + 1'b1);
    if (cmd.take) begin
      rd_addr = (in_limit || in_req_type == REQ_CLEANUP) ? '0 : in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Hook enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hook_en_r <= '0;
    end else if (cfg_wr_en) begin
      hook_en_r <= cfg_wr_data;
    end
  end

  // Request capture and cleanup counter
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_r        <= in_req_type;
      task_r       <= in_task_slot;
      idx_r        <= in_idx;
      limit_r      <= in_limit;
      method_r     <= in_method;
      mask_after_r <= in_mask_after;
      alloc_ok_r   <= in_alloc_ok;
      sender_r     <= in_sender_id;
      arg1_r       <= in_arg_one;
      arg2_r       <= in_arg_two;
      arg3_r       <= in_arg_three;
      arg4_r       <= in_arg_four;
      arg5_r       <= in_arg_five;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.take) begin
      cnt_r <= '0;
    end else if (cmd.clean) begin
      cnt_r <= SLOT_W'(cnt_r + 1'b1);
    end
  end

  assign clean_hit = cmd.clean && sub_r[cnt_r] && (rd_data_r.owner == task_r);

  // Per-request decision on the slot read back from the table
  always_comb begin
    cur_sub    = sub_r[idx_r];
    new_serial = rd_data_r.serial + 1'b1;
    st         = ST_OK;
    nv         = 1'b0;
    hook       = 1'b0;
    set_sub    = 1'b0;
    clr_sub    = 1'b0;
    wr_en      = 1'b0;
    wr_data    = rd_data_r;
    if (req_r == REQ_CLEANUP) begin
      st = ST_OK;
    end else if (limit_r) begin
      st = ST_LIMIT;
    end else begin
      unique case (req_r)
        REQ_NOTIFY: begin
          if (!cur_sub) begin
            st = ST_NOSUB;
          end else if (rd_data_r.masked) begin
            st = ST_BUSY;
          end else if (!alloc_ok_r) begin
            st = ST_NOMEM;
          end else begin
            nv             = 1'b1;
            wr_en          = cmd.commit;
            wr_data.serial = new_serial;
            wr_data.masked = mask_after_r;
          end
        end
        REQ_SUBSCRIBE: begin
          if (cur_sub) begin
            st = ST_EXIST;
          end else begin
            set_sub        = cmd.commit;
            wr_en          = cmd.commit;
            wr_data.owner  = task_r;
            wr_data.method = method_r;
            wr_data.serial = '0;
            wr_data.masked = 1'b0;
          end
        end
        REQ_UNSUB: begin
          if (cur_sub && rd_data_r.owner == task_r) begin
            clr_sub = cmd.commit;
          end else begin
            st = ST_NOSUB;
          end
        end
        REQ_UNMASK: begin
          // a free slot is not written; subscribe rewrites every field
          wr_en          = cmd.commit && cur_sub;
          wr_data.masked = 1'b0;
          hook           = (int'(idx_r) < GLOBAL_EVENTS) &&
                           hook_en_r[HOOK_IDX_W'(idx_r)];
        end
        default: begin
          st = ST_LIMIT;
        end
      endcase
    end
  end

  // Subscribed flags; a clear flag means the entry's table content is not used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= '0;
    end else begin
      if (clean_hit) begin
        sub_r[cnt_r] <= 1'b0;
      end
      if (set_sub) begin
        sub_r[idx_r] <= 1'b1;
      end
      if (clr_sub) begin
        sub_r[idx_r] <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r  <= st;
      nv_r      <= nv;
      hook_r    <= hook;
      owner_r   <= nv ? rd_data_r.owner  : '0;
      nmethod_r <= nv ? rd_data_r.method : '0;
      serial_r  <= nv ? new_serial       : '0;
      nsender_r <= nv ? sender_r         : '0;
      oarg1_r   <= nv ? arg1_r           : '0;
      oarg2_r   <= nv ? arg2_r           : '0;
      oarg3_r   <= nv ? arg3_r           : '0;
      oarg4_r   <= nv ? arg4_r           : '0;
      oarg5_r   <= nv ? arg5_r           : '0;
    end
  end

  // Status to controller
  always_comb begin
    sts.req_clean  = (in_req_type == REQ_CLEANUP);
    sts.clean_last = (int'(cnt_r) == GLOBAL_EVENTS - 1);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_notif_valid  = nv_r;
  assign out_notif_owner  = owner_r;
  assign out_notif_method = nmethod_r;
  assign out_notif_serial = serial_r;
  assign out_notif_sender = nsender_r;
  assign out_arg_one      = oarg1_r;
  assign out_arg_two      = oarg2_r;
  assign out_arg_three    = oarg3_r;
  assign out_arg_four     = oarg4_r;
  assign out_arg_five     = oarg5_r;
  assign out_unmask_hook  = hook_r;

endmodule

`default_nettype wire
